// ===== rtl/core/ambe_pkg.sv =====
//------------------------------------------------------------------------------
// ambe_pkg
// Types and constants for the ARM mode bank and exception unit.
//------------------------------------------------------------------------------
package ambe_pkg;

    localparam logic [2:0] CMD_STEP  = 3'd0;
    localparam logic [2:0] CMD_FIQ   = 3'd1;
    localparam logic [2:0] CMD_MODE  = 3'd2;
    localparam logic [2:0] CMD_COND  = 3'd3;
    localparam logic [2:0] CMD_FLAGS = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;
    localparam logic [2:0] CMD_WRITE = 3'd6;
    localparam logic [2:0] CMD_RSVD  = 3'd7;

    localparam logic [31:0] PC_RESET = 32'h0800_0000;
    localparam logic [31:0] SP_USER  = 32'h0300_7F00;
    localparam logic [31:0] SP_IRQ   = 32'h0300_7FA0;
    localparam logic [31:0] SP_OTHER = 32'h0300_7FE0;
    localparam logic [4:0]  MODE_FIQ = 5'h11;
    localparam logic [4:0]  MODE_IRQ = 5'h12;
    localparam logic [4:0]  MODE_SYS = 5'h1F;
    localparam logic [31:0] VEC_IRQ  = 32'h18;
    localparam logic [31:0] VEC_FIQ  = 32'h1C;

    // memory map of the single bank RAM
    localparam int unsigned BANK_AW    = 6;
    localparam int unsigned BANK_DEPTH = 64;
    localparam logic [5:0] A_GPR  = 6'd0;   // 0..15 live registers
    localparam logic [5:0] A_SP   = 6'd16;  // 16..21
    localparam logic [5:0] A_LR   = 6'd24;  // 24..29
    localparam logic [5:0] A_SPSR = 6'd32;  // 32..37
    localparam logic [5:0] A_FIQH = 6'd40;  // 40..44
    localparam logic [5:0] A_NRMH = 6'd48;  // 48..52

    typedef struct packed {
        logic [2:0]  cmd;
        logic        irq_pending;
        logic [4:0]  mode_sel;
        logic [3:0]  cond_code;
        logic [3:0]  reg_index;
        logic [31:0] data_in;
        logic        carry_in;
        logic        overflow_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0] data_out;
        logic        fetch_valid;
        logic        took_irq;
        logic        cond_pass;
        logic [31:0] status_out;
        logic [31:0] cycle_count;
    } t_out_word;

    function automatic logic [2:0] group_of(input logic [4:0] mode);
        case (mode)
            5'h11:   group_of = 3'd1;
            5'h12:   group_of = 3'd2;
            5'h13:   group_of = 3'd3;
            5'h17:   group_of = 3'd4;
            5'h1B:   group_of = 3'd5;
            default: group_of = 3'd0;
        endcase
    endfunction

    function automatic logic cond_ok(input logic [31:0] sw, input logic [3:0] c);
        logic n, z, cf, v;
        n = sw[31]; z = sw[30]; cf = sw[29]; v = sw[28];
        case (c)
            4'h0:    cond_ok = z;
            4'h1:    cond_ok = !z;
            4'h2:    cond_ok = cf;
            4'h3:    cond_ok = !cf;
            4'h4:    cond_ok = n;
            4'h5:    cond_ok = !n;
            4'h6:    cond_ok = v;
            4'h7:    cond_ok = !v;
            4'h8:    cond_ok = cf && !z;
            4'h9:    cond_ok = !cf || z;
            4'hA:    cond_ok = n == v;
            4'hB:    cond_ok = n != v;
            4'hC:    cond_ok = !z && (n == v);
            4'hD:    cond_ok = z || (n != v);
            4'hE:    cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    endfunction

endpackage

// ===== rtl/core/ambe_ram.sv =====
//------------------------------------------------------------------------------
// ambe_ram
// Generic single-port synchronous RAM with registered read.
//------------------------------------------------------------------------------
module ambe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/core/arm_mode_bank_exception_unit_top.sv =====
//------------------------------------------------------------------------------
// arm_mode_bank_exception_unit_top
// ARM mode/bank unit: live registers, banks and saved status in one RAM,
// walked by a microsequencer.
//------------------------------------------------------------------------------
// channel  | signals                  | handshake
// command  | i_cmd_word, start, busy  | taken when start && !busy
// result   | o_res_word, o_res_valid  | one-cycle strobe, no back-pressure
//
// Each RAM access is one sequencer step (one port, registered read).
// A mode switch makes fourteen word moves; an exception writes the saved
// status and banked LR, makes the moves unless already in the target mode,
// then writes r14 and r15; the next word is taken only once busy drops.
// After reset a clearing pass over all 64 words loads the reset values; busy
// stays high meanwhile. The result strobe is never stalled.
//------------------------------------------------------------------------------
module arm_mode_bank_exception_unit_top
    import ambe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd_word,
    output logic      o_res_valid,
    output t_out_word o_res_word
);
    localparam int AW = BANK_AW;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,  // issue read of r_addr
        S_RW    = 7'b0001000,  // data returns; act, maybe go on to write
        S_PLAN  = 7'b0010000,  // choose next micro-op
        S_WR    = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state      r_state;
    t_in_word    r_cmd;
    logic [AW-1:0] r_addr;
    logic [31:0] r_sw, r_cyc, r_tmp, r_ret;
    logic [4:0]  r_step;    // micro-op index
    logic [4:0]  r_tgt;     // target mode
    logic [4:0]  r_old;
    logic        r_exc, r_irq, r_fetch;
    logic [31:0] r_dout;
    logic        r_pass;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    ambe_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // reset image for the clearing pass
    function automatic logic [31:0] init_val(input logic [AW-1:0] a);
        logic [5:0] a6;
        a6 = 6'(a);
        if (a6 == 6'd15) init_val = PC_RESET;
        else if (a6 == A_SP) init_val = SP_USER;
        else if (a6 == A_SP + 6'd2) init_val = SP_IRQ;
        else if (a6 > A_SP && a6 < A_SP + 6'd6) init_val = SP_OTHER;
        else init_val = '0;
    endfunction

    // Mode switch as a list of moves: step k < 7 saves live reg to bank,
    // step 7..13 loads bank to live reg.
    // live regs in order: 13,14,8..12
    function automatic logic [5:0] live_a(input logic [4:0] k);
        logic [2:0] j;
        j = (k < 5'd7) ? k[2:0] : 3'(k - 5'd7);
        case (j)
            3'd0:    live_a = 6'd13;
            3'd1:    live_a = 6'd14;
            default: live_a = 6'd8 + 6'(j - 3'd2);
        endcase
    endfunction

    function automatic logic [5:0] bank_a(input logic [4:0] k, input logic [4:0] mode);
        logic [2:0] j;
        j = (k < 5'd7) ? k[2:0] : 3'(k - 5'd7);
        case (j)
            3'd0:    bank_a = A_SP + 6'(group_of(mode));
            3'd1:    bank_a = A_LR + 6'(group_of(mode));
            default: bank_a = ((mode == MODE_FIQ) ? A_FIQH : A_NRMH) + 6'(j - 3'd2);
        endcase
    endfunction

    logic [5:0] src_a, dst_a;
    always_comb begin
        if (r_step < 5'd7) begin
            src_a = live_a(r_step);
            dst_a = bank_a(r_step, r_old);
        end else begin
            src_a = bank_a(r_step, r_tgt);
            dst_a = live_a(r_step);
        end
    end

    // micro-op phases (r_step beyond moves)
    localparam logic [4:0] ST_MOVES_END = 5'd14;
    localparam logic [4:0] ST_SPSR      = 5'd20;  // saved status written
    localparam logic [4:0] ST_LR        = 5'd21;  // banked LR written
    localparam logic [4:0] ST_PC        = 5'd22;  // live r14 written
    localparam logic [4:0] ST_LAST      = 5'd31;  // final write

    assign busy = (r_state != S_IDLE);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = r_tmp;
        if (r_state == S_INIT) begin
            ram_we    = 1'b1;
            ram_wdata = init_val(r_addr);
        end else if (r_state == S_WR) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
            r_state <= S_INIT;
            r_addr  <= '0;
            r_sw    <= {27'd0, MODE_SYS};
            r_cyc   <= '0;
        end else begin
            o_res_valid <= (r_state == S_DONE);
            case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(BANK_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd_word;
                        r_dout  <= '0;
                        r_pass  <= (i_cmd_word.cmd == CMD_COND) &&
                                   cond_ok(r_sw, i_cmd_word.cond_code);
                        r_fetch <= 1'b0;
                        r_irq   <= 1'b0;
                        r_exc   <= 1'b0;
                        case (i_cmd_word.cmd)
                            CMD_STEP, CMD_FIQ: begin
                                r_addr  <= AW'(15);
                                r_state <= S_RD;
                            end
                            CMD_MODE: begin
                                r_old  <= r_sw[4:0];
                                r_tgt  <= i_cmd_word.mode_sel;
                                r_step <= '0;
                                r_state <= (i_cmd_word.mode_sel == r_sw[4:0]) ?
                                           S_DONE : S_PLAN;
                            end
                            CMD_COND: begin
                                r_state <= S_DONE;
                            end
                            CMD_FLAGS: begin
                                r_sw[31] <= i_cmd_word.data_in[31];
                                r_sw[30] <= (i_cmd_word.data_in == '0);
                                r_sw[29] <= i_cmd_word.carry_in;
                                r_sw[28] <= i_cmd_word.overflow_in;
                                r_state  <= S_DONE;
                            end
                            CMD_READ: begin
                                r_addr  <= AW'(i_cmd_word.reg_index);
                                r_state <= S_RD;
                            end
                            CMD_WRITE: begin
                                r_addr  <= AW'(i_cmd_word.reg_index);
                                r_tmp   <= i_cmd_word.data_in;
                                r_step  <= ST_LAST;
                                r_state <= S_WR;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: r_state <= S_RW;
                S_RW: begin
                    // r_step meaning while here: move (<14) or special
                    if (r_cmd.cmd == CMD_READ) begin
                        r_dout  <= ram_rdata;
                        r_state <= S_DONE;
                    end else if (!r_exc && (r_cmd.cmd == CMD_STEP ||
                                            r_cmd.cmd == CMD_FIQ)) begin
                        // r15 read
                        if (r_cmd.cmd == CMD_STEP &&
                            !(!r_sw[7] && r_cmd.irq_pending)) begin
                            r_dout  <= ram_rdata;
                            r_fetch <= 1'b1;
                            r_tmp   <= ram_rdata + 32'd4;
                            r_cyc   <= r_cyc + 32'd1;
                            r_step  <= ST_LAST;
                            r_state <= S_WR;
                        end else begin
                            r_exc <= 1'b1;
                            r_irq <= (r_cmd.cmd == CMD_STEP);
                            r_tgt <= (r_cmd.cmd == CMD_STEP) ? MODE_IRQ : MODE_FIQ;
                            r_old <= r_sw[4:0];
                            r_ret <= ram_rdata - 32'd4;
                            // save status to target's saved slot
                            r_addr <= AW'(A_SPSR + 6'(group_of(
                                (r_cmd.cmd == CMD_STEP) ? MODE_IRQ : MODE_FIQ)));
                            r_tmp  <= r_sw;
                            r_step <= ST_SPSR;
                            r_state <= S_WR;
                        end
                    end else begin
                        // bank move: data read, write to destination
                        r_tmp   <= ram_rdata;
                        r_addr  <= AW'(dst_a);
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    // after write, advance
                    if (r_step == ST_LAST) begin
                        r_state <= S_DONE;
                    end else if (r_step == ST_SPSR) begin
                        // banked LR of target = ret
                        r_addr <= AW'(A_LR + 6'(group_of(r_tgt)));
                        r_tmp  <= r_ret;
                        r_step <= ST_LR;
                    end else if (r_step == ST_LR) begin
                        r_step  <= (r_old == r_tgt) ? ST_MOVES_END : '0;
                        r_state <= S_PLAN;
                    end else if (r_step == ST_PC) begin
                        r_addr <= AW'(15);
                        r_tmp  <= (r_tgt == MODE_FIQ) ? VEC_FIQ : VEC_IRQ;
                        r_step <= ST_LAST;
                        r_sw   <= {r_sw[31:8], 1'b1,
                                   (r_tgt == MODE_FIQ) ? 1'b1 : r_sw[6],
                                   1'b0, r_sw[4:0]};
                        r_cyc  <= r_cyc + 32'd3;
                    end else begin
                        if (r_step == 5'd6) r_sw[4:0] <= r_tgt;
                        r_step  <= r_step + 5'd1;
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    if (r_step >= ST_MOVES_END) begin
                        if (r_exc) begin
                            r_addr  <= AW'(14);
                            r_tmp   <= r_ret;
                            r_step  <= ST_PC;
                            r_state <= S_WR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_addr  <= AW'(src_a);
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    o_res_word  <= '{data_out: r_dout, fetch_valid: r_fetch,
                                     took_irq: r_irq, cond_pass: r_pass,
                                     status_out: r_sw, cycle_count: r_cyc};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== verif/ambe_checker.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// ambe_checker
// Watches the command and result channels of the mode/bank unit, keeps its
// own copy of the register banks, predicts each result word and compares.
//------------------------------------------------------------------------------
module ambe_checker
    import ambe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_cmd_word,
    input  logic      i_res_valid,
    input  t_out_word i_res_word,
    output int        o_fail_count,
    output int        o_pending
);

    logic [31:0] regs [16];
    logic [31:0] cpsr;
    logic [31:0] spsr [6];
    logic [31:0] sp_bank [6];
    logic [31:0] lr_bank [6];
    logic [31:0] fiq_hi [5];
    logic [31:0] nrm_hi [5];
    logic [31:0] cyc;

    t_out_word expected_words [$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_words.size();

    function automatic int bank_of(input logic [4:0] m);
        case (m)
            5'h11:   return 1;
            5'h12:   return 2;
            5'h13:   return 3;
            5'h17:   return 4;
            5'h1B:   return 5;
            default: return 0;
        endcase
    endfunction

    task automatic reset_banks();
        for (int i = 0; i < 16; i++) regs[i] = '0;
        regs[15] = PC_RESET;
        cpsr = {27'd0, MODE_SYS};
        for (int i = 0; i < 6; i++) begin
            spsr[i] = '0;
            lr_bank[i] = '0;
            sp_bank[i] = SP_OTHER;
        end
        sp_bank[0] = SP_USER;
        sp_bank[2] = SP_IRQ;
        for (int i = 0; i < 5; i++) begin
            fiq_hi[i] = '0;
            nrm_hi[i] = '0;
        end
        cyc = '0;
    endtask

    task automatic switch_bank(input logic [4:0] m);
        logic [4:0] old;
        int g;
        old = cpsr[4:0];
        if (old != m) begin
            g = bank_of(old);
            sp_bank[g] = regs[13];
            lr_bank[g] = regs[14];
            for (int i = 0; i < 5; i++) begin
                if (old == MODE_FIQ) fiq_hi[i] = regs[8+i];
                else nrm_hi[i] = regs[8+i];
            end
            cpsr[4:0] = m;
            g = bank_of(m);
            regs[13] = sp_bank[g];
            regs[14] = lr_bank[g];
            for (int i = 0; i < 5; i++)
                regs[8+i] = (m == MODE_FIQ) ? fiq_hi[i] : nrm_hi[i];
        end
    endtask

    task automatic take_exception(input logic [4:0] m, input logic [31:0] mask,
                                  input logic [31:0] vec);
        int g;
        logic [31:0] ret;
        g = bank_of(m);
        ret = regs[15] - 32'd4;
        spsr[g] = cpsr;
        lr_bank[g] = ret;
        switch_bank(m);
        regs[14] = ret;
        cpsr = cpsr | mask;
        cpsr[5] = 1'b0;
        regs[15] = vec;
        cyc += 32'd3;
    endtask

    function automatic logic cond_met(input logic [3:0] c);
        logic n, z, cf, v;
        n = cpsr[31]; z = cpsr[30]; cf = cpsr[29]; v = cpsr[28];
        case (c)
            4'h0:    return z;
            4'h1:    return !z;
            4'h2:    return cf;
            4'h3:    return !cf;
            4'h4:    return n;
            4'h5:    return !n;
            4'h6:    return v;
            4'h7:    return !v;
            4'h8:    return cf && !z;
            4'h9:    return !cf || z;
            4'hA:    return n == v;
            4'hB:    return n != v;
            4'hC:    return !z && (n == v);
            4'hD:    return z || (n != v);
            4'hE:    return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic predict_word(input t_in_word w);
        t_out_word r;
        r = '0;
        case (w.cmd)
            CMD_STEP: begin
                if (!cpsr[7] && w.irq_pending) begin
                    take_exception(MODE_IRQ, 32'h80, VEC_IRQ);
                    r.took_irq = 1'b1;
                end else begin
                    r.data_out = regs[15];
                    regs[15] += 32'd4;
                    cyc += 32'd1;
                    r.fetch_valid = 1'b1;
                end
            end
            CMD_FIQ:   take_exception(MODE_FIQ, 32'hC0, VEC_FIQ);
            CMD_MODE:  switch_bank(w.mode_sel);
            CMD_COND:  r.cond_pass = cond_met(w.cond_code);
            CMD_FLAGS: begin
                cpsr[31] = w.data_in[31];
                cpsr[30] = (w.data_in == 32'd0);
                cpsr[29] = w.carry_in;
                cpsr[28] = w.overflow_in;
            end
            CMD_READ:  r.data_out = regs[w.reg_index];
            CMD_WRITE: regs[w.reg_index] = w.data_in;
            default: ;
        endcase
        r.status_out  = cpsr;
        r.cycle_count = cyc;
        expected_words.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            reset_banks();
            expected_words.delete();
        end else begin
            if (i_res_valid) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", 32'd0, 32'd0);
                end else begin
                    e = expected_words.pop_front();
                    if (i_res_word.data_out !== e.data_out)
                        report("data_out", i_res_word.data_out, e.data_out);
                    if (i_res_word.fetch_valid !== e.fetch_valid)
                        report("fetch_valid", 32'(i_res_word.fetch_valid), 32'(e.fetch_valid));
                    if (i_res_word.took_irq !== e.took_irq)
                        report("took_irq", 32'(i_res_word.took_irq), 32'(e.took_irq));
                    if (i_res_word.cond_pass !== e.cond_pass)
                        report("cond_pass", 32'(i_res_word.cond_pass), 32'(e.cond_pass));
                    if (i_res_word.status_out !== e.status_out)
                        report("status_out", i_res_word.status_out, e.status_out);
                    if (i_res_word.cycle_count !== e.cycle_count)
                        report("cycle_count", i_res_word.cycle_count, e.cycle_count);
                end
            end
            // result of a word can't appear in the cycle it is taken
            if (i_start && !i_busy) predict_word(i_cmd_word);
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Drives directed then random command words into the mode/bank unit in
// bursts with gaps; the checker predicts and compares every result word.
//------------------------------------------------------------------------------
module testbench;
    import ambe_pkg::*;

    localparam int NUM_RANDOM = 1700;
    localparam int IDLE_LIMIT = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  cmd_word;
    logic      res_valid;
    t_out_word res_word;
    int        fail_count;
    int        pending;
    int        idle_cycles;

    arm_mode_bank_exception_unit_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd_word (cmd_word),
        .o_res_valid(res_valid),
        .o_res_word (res_word)
    );

    ambe_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd_word  (cmd_word),
        .i_res_valid (res_valid),
        .i_res_word  (res_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog: cycles with no accepted command and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || res_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [4:0] pick_mode();
        case ($urandom_range(0, 9))
            0: return 5'h10;
            1: return 5'h11;
            2: return 5'h12;
            3: return 5'h13;
            4: return 5'h17;
            5: return 5'h1B;
            6: return 5'h1F;
            default: return 5'($urandom);
        endcase
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int r;
        w = t_in_word'($bits(t_in_word)'({$urandom, $urandom}));
        w.mode_sel = pick_mode();
        r = $urandom_range(0, 99);
        if (r < 20)      w.cmd = CMD_STEP;
        else if (r < 25) w.cmd = CMD_FIQ;
        else if (r < 40) w.cmd = CMD_MODE;
        else if (r < 52) w.cmd = CMD_COND;
        else if (r < 62) w.cmd = CMD_FLAGS;
        else if (r < 78) w.cmd = CMD_READ;
        else if (r < 96) w.cmd = CMD_WRITE;
        else             w.cmd = CMD_RSVD;
        if ($urandom_range(0, 7) == 0) w.data_in = 32'd0;
        if ($urandom_range(0, 7) == 0) w.data_in = 32'hFFFF_FFFF;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        start    <= 1'b1;
        cmd_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_gap();
        if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input logic [2:0] c, input logic [4:0] m,
                            input logic [3:0] cc, input logic [3:0] ri,
                            input logic [31:0] d, input logic irq,
                            input logic ca, input logic ov);
        t_in_word w;
        w.cmd = c; w.irq_pending = irq; w.mode_sel = m; w.cond_code = cc;
        w.reg_index = ri; w.data_in = d; w.carry_in = ca; w.overflow_in = ov;
        send_word(w);
        send_gap();
    endtask

    initial begin
        int burst;
        start       <= 1'b0;
        cmd_word    <= '0;
        i_rst_n     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fetch, IRQ, FIQ, modes, flags, conditions, regs
        send_cmd(CMD_READ, 0, 0, 4'd15, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 4'd13, 0, 0, 0, 0);
        send_cmd(CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0);
        send_cmd(CMD_WRITE, 0, 0, 4'd8, 32'hFFFF_FFFF, 0, 0, 0);
        send_cmd(CMD_WRITE, 0, 0, 4'd12, 32'h1234_5678, 0, 0, 0);
        send_cmd(CMD_STEP, 0, 0, 0, 0, 1'b1, 0, 0);
        send_cmd(CMD_STEP, 0, 0, 0, 0, 1'b1, 0, 0);    // I set: fetch
        send_cmd(CMD_FIQ, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_FIQ, 0, 0, 0, 0, 0, 0, 0);        // already in FIQ
        send_cmd(CMD_WRITE, 0, 0, 4'd9, 32'hA5A5_A5A5, 0, 0, 0);
        send_cmd(CMD_MODE, 5'h10, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 4'd8, 0, 0, 0, 0);
        send_cmd(CMD_MODE, 5'h10, 0, 0, 0, 0, 0, 0);   // same mode
        send_cmd(CMD_MODE, 5'h00, 0, 0, 0, 0, 0, 0);   // meaningless code
        send_cmd(CMD_MODE, 5'h11, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 4'd9, 0, 0, 0, 0);
        send_cmd(CMD_FLAGS, 0, 0, 0, 32'd0, 0, 1'b1, 1'b1);
        for (int c = 0; c < 16; c += 3)
            send_cmd(CMD_COND, 0, 4'(c), 0, 0, 0, 0, 0);
        send_cmd(CMD_FLAGS, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
        send_cmd(CMD_COND, 0, 4'hB, 0, 0, 0, 0, 0);
        send_cmd(CMD_COND, 0, 4'hF, 0, 0, 0, 0, 0);
        send_cmd(CMD_RSVD, 5'h1F, 4'hF, 4'hF, 32'hFFFF_FFFF, 1, 1, 1);

        for (int n = 0; n < NUM_RANDOM; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++)
                send_word(rand_word());
            start <= 1'b0;
            if ($urandom_range(0, 1) != 0)
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
